// ----- src/hufm_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants, mode codes and controller/datapath interface structs
// for the Huffman tree merge engine. No dependencies.
package hufm_pkg;

    localparam int SYMBOLS     = 256;
    localparam int STORE_DEPTH = 512;
    localparam int NODE_W      = $clog2(STORE_DEPTH);
    localparam int NEXT_W      = NODE_W + 1;
    localparam int WEIGHT_W    = 40;
    localparam int FREQ_W      = 32;
    localparam int SYM_W       = 8;
    localparam int MODE_W      = 2;

    localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_MERGE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;         // write the incoming frequency into its leaf
        logic clear_start;  // restart the leaf clearing pass
        logic clear_step;   // zero one leaf and advance
        logic scan_start;   // reset the selection and the scan address
        logic scan_step;    // issue one read and advance
        logic wr_sum;       // store the parent weight
        logic wr_left;      // zero the best child
        logic wr_right;     // zero the second child, bump next_node
        logic report_merge;
        logic report_done;
    } hufm_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_last;
        logic scan_last;
        logic can_merge;
        logic full;
    } hufm_sts_t;

endpackage

// ----- src/hufm_ctrl.sv -----
`timescale 1ns / 1ps
// Sequencing state machine of the Huffman tree merge engine.
// Depends on hufm_pkg for mode codes and the command/status structs.
module hufm_ctrl
    import hufm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [MODE_W-1:0] mode,
    input  hufm_sts_t         sts,
    output hufm_cmd_t         cmd,
    output logic              busy
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH,
        ST_DECIDE,
        ST_WR_SUM,
        ST_WR_LEFT,
        ST_WR_RIGHT
    } state_t;

    state_t state_reg, state_next;

    assign busy = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (sts.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    case (mode)
                        MODE_LOAD:
                        begin
                            cmd.load = 1'b1;
                        end
                        MODE_MERGE:
                        begin
                            cmd.scan_start = 1'b1;
                            // A full store answers as a finished tree without a scan.
                            state_next = sts.full ? ST_DECIDE : ST_SCAN;
                        end
                        MODE_CLEAR:
                        begin
                            cmd.clear_start = 1'b1;
                            state_next      = ST_CLEAR;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                // The last read word is compared during this cycle.
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (sts.can_merge && !sts.full)
                begin
                    state_next = ST_WR_SUM;
                end
                else
                begin
                    cmd.report_done = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            ST_WR_SUM:
            begin
                cmd.wr_sum = 1'b1;
                state_next = ST_WR_LEFT;
            end
            ST_WR_LEFT:
            begin
                cmd.wr_left = 1'b1;
                state_next  = ST_WR_RIGHT;
            end
            ST_WR_RIGHT:
            begin
                cmd.wr_right     = 1'b1;
                cmd.report_merge = 1'b1;
                state_next       = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- src/hufm_datapath.sv -----
`timescale 1ns / 1ps
// Weight store, scan address, running best/second selection and result
// registers of the Huffman tree merge engine. Depends on hufm_pkg.
module hufm_datapath
    import hufm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  hufm_cmd_t           cmd,
    input  logic [SYM_W-1:0]    symbol,
    input  logic [FREQ_W-1:0]   frequency,
    output hufm_sts_t           sts,
    output logic                strobe,
    output logic                done_res,
    output logic [NODE_W-1:0]   left_node,
    output logic [NODE_W-1:0]   right_node,
    output logic [NODE_W-1:0]   new_node,
    output logic [WEIGHT_W-1:0] merged_weight
);

    logic [WEIGHT_W-1:0] mem [STORE_DEPTH];

    logic [NEXT_W-1:0]   next_node_reg;
    logic [NODE_W-1:0]   addr_reg;
    logic [WEIGHT_W-1:0] rd_data_reg;
    logic                rd_vld_reg;
    logic [NODE_W-1:0]   rd_idx_reg;

    logic [WEIGHT_W-1:0] best_w_reg, best_w_next;
    logic [NODE_W-1:0]   best_i_reg, best_i_next;
    logic                have_best_reg, have_best_next;
    logic [WEIGHT_W-1:0] sec_w_reg, sec_w_next;
    logic [NODE_W-1:0]   sec_i_reg, sec_i_next;
    logic                have_sec_reg, have_sec_next;

    logic [WEIGHT_W-1:0] sum_reg;
    logic                strobe_reg;
    logic                done_reg;
    logic [NODE_W-1:0]   left_reg, right_reg, new_reg;
    logic [WEIGHT_W-1:0] weight_reg;

    logic                wr_en;
    logic [NODE_W-1:0]   wr_addr;
    logic [WEIGHT_W-1:0] wr_data;
    logic [WEIGHT_W:0]   sum_full;
    logic [WEIGHT_W-1:0] sum_sat;
    logic [NODE_W-1:0]   last_idx;
    logic [NODE_W:0]     load_idx;

    assign sum_full = {1'b0, best_w_reg} + {1'b0, sec_w_reg};
    assign sum_sat  = sum_full[WEIGHT_W] ? {WEIGHT_W{1'b1}} : sum_full[WEIGHT_W-1:0];
    assign last_idx = next_node_reg[NODE_W-1:0] - NODE_W'(1);
    assign load_idx = {1'b0, NODE_W'(symbol)};

    assign sts.clear_last = (addr_reg == NODE_W'(SYMBOLS - 1));
    assign sts.scan_last  = (addr_reg == last_idx);
    assign sts.can_merge  = have_best_reg && have_sec_reg;
    assign sts.full       = (next_node_reg >= NEXT_W'(STORE_DEPTH));

    // Single write port shared by loads, clearing, and merge write-back.
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = addr_reg;
        wr_data = '0;
        if (cmd.load)
        begin
            wr_en   = (load_idx < (NODE_W + 1)'(SYMBOLS));
            wr_addr = load_idx[NODE_W-1:0];
            wr_data = WEIGHT_W'(frequency);
        end
        else if (cmd.clear_step)
        begin
            wr_en   = 1'b1;
            wr_addr = addr_reg;
        end
        else if (cmd.wr_sum)
        begin
            wr_en   = 1'b1;
            wr_addr = next_node_reg[NODE_W-1:0];
            wr_data = sum_sat;
        end
        else if (cmd.wr_left)
        begin
            wr_en   = 1'b1;
            wr_addr = best_i_reg;
        end
        else if (cmd.wr_right)
        begin
            wr_en   = 1'b1;
            wr_addr = sec_i_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[addr_reg];
    end

    // Running selection over the words coming back from the store.
    always_comb
    begin
        best_w_next    = best_w_reg;
        best_i_next    = best_i_reg;
        have_best_next = have_best_reg;
        sec_w_next     = sec_w_reg;
        sec_i_next     = sec_i_reg;
        have_sec_next  = have_sec_reg;
        if (cmd.scan_start)
        begin
            have_best_next = 1'b0;
            have_sec_next  = 1'b0;
        end
        else if (rd_vld_reg && (rd_data_reg != '0))
        begin
            if (!have_best_reg)
            begin
                best_w_next    = rd_data_reg;
                best_i_next    = rd_idx_reg;
                have_best_next = 1'b1;
            end
            else if (rd_data_reg <= best_w_reg)
            begin
                sec_w_next     = best_w_reg;
                sec_i_next     = best_i_reg;
                have_sec_next  = 1'b1;
                best_w_next    = rd_data_reg;
                best_i_next    = rd_idx_reg;
            end
            else if (!have_sec_reg || (rd_data_reg <= sec_w_reg))
            begin
                sec_w_next    = rd_data_reg;
                sec_i_next    = rd_idx_reg;
                have_sec_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_node_reg <= NEXT_W'(SYMBOLS);
            addr_reg      <= '0;
            rd_vld_reg    <= 1'b0;
            have_best_reg <= 1'b0;
            have_sec_reg  <= 1'b0;
            strobe_reg    <= 1'b0;
        end
        else
        begin
            rd_vld_reg    <= cmd.scan_step;
            have_best_reg <= have_best_next;
            have_sec_reg  <= have_sec_next;
            strobe_reg    <= cmd.report_merge || cmd.report_done;
            if (cmd.clear_start)
            begin
                next_node_reg <= NEXT_W'(SYMBOLS);
                addr_reg      <= '0;
            end
            else if (cmd.scan_start)
            begin
                addr_reg <= '0;
            end
            else if (cmd.clear_step || cmd.scan_step)
            begin
                addr_reg <= addr_reg + NODE_W'(1);
            end
            if (cmd.wr_right)
            begin
                next_node_reg <= next_node_reg + NEXT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg <= addr_reg;
        best_w_reg <= best_w_next;
        best_i_reg <= best_i_next;
        sec_w_reg  <= sec_w_next;
        sec_i_reg  <= sec_i_next;
        if (cmd.wr_sum)
        begin
            sum_reg <= sum_sat;
        end
        if (cmd.report_merge)
        begin
            done_reg   <= 1'b0;
            left_reg   <= best_i_reg;
            right_reg  <= sec_i_reg;
            new_reg    <= next_node_reg[NODE_W-1:0];
            weight_reg <= sum_reg;
        end
        else if (cmd.report_done)
        begin
            done_reg   <= 1'b1;
            left_reg   <= '0;
            right_reg  <= '0;
            new_reg    <= last_idx;
            weight_reg <= '0;
        end
    end

    assign strobe        = strobe_reg;
    assign done_res      = done_reg;
    assign left_node     = left_reg;
    assign right_node    = right_reg;
    assign new_node      = new_reg;
    assign merged_weight = weight_reg;

endmodule

// ----- src/huffman_tree_merge_engine.sv -----
`timescale 1ns / 1ps
// Top level of the Huffman tree merge engine: controller plus datapath.
// Depends on hufm_pkg, hufm_ctrl and hufm_datapath.
//
// An item is taken when start is high and busy is low. A load (mode 0)
// leaves busy low. A clear (mode 2) keeps busy high while the leaf
// weights are zeroed one per cycle, and the same pass runs right after
// reset, so nothing is taken until it ends. A merge (mode 1) reads the
// weight store one node per cycle through its single read port and stays
// busy through the scan, and through the write-back when it merges; a
// merge with the store already full skips the scan. Each merge gives one
// result, shown for exactly one cycle with strobe high in the first cycle
// that busy is low again; there is no way to hold it, so the receiver
// must take it then.
module huffman_tree_merge_engine
    import hufm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [MODE_W-1:0]   mode,
    input  logic [SYM_W-1:0]    symbol,
    input  logic [FREQ_W-1:0]   frequency,
    output logic                strobe,
    output logic                done_res,
    output logic [NODE_W-1:0]   left_node,
    output logic [NODE_W-1:0]   right_node,
    output logic [NODE_W-1:0]   new_node,
    output logic [WEIGHT_W-1:0] merged_weight
);

    hufm_cmd_t cmd;
    hufm_sts_t sts;

    hufm_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .mode  (mode),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    hufm_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .symbol        (symbol),
        .frequency     (frequency),
        .sts           (sts),
        .strobe        (strobe),
        .done_res      (done_res),
        .left_node     (left_node),
        .right_node    (right_node),
        .new_node      (new_node),
        .merged_weight (merged_weight)
    );

    // A finished tree reports no children and no weight.
    a_done_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && done_res) |-> (left_node == '0 && right_node == '0 &&
                                  merged_weight == '0))
        else $error("done result carries child fields");

    // Merges and clears occupy the engine for at least the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (mode == MODE_MERGE || mode == MODE_CLEAR)) |=> busy)
        else $error("engine idle right after a merge or clear was taken");

    // A result only follows a merge that kept the engine busy.
    a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> $past(busy))
        else $error("result without preceding work");

    // Each merge gives exactly one result cycle.
    a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |=> !strobe)
        else $error("result strobe held for more than one cycle");

endmodule
